FILE: rtl/pok_pkg.sv
// ----------------------------------------------------------------------------
// pok_pkg: shared types, constants and helpers for the kinematics block
// Holds the CORDIC constants, the arctangent table, the rounding and
// saturation helpers and the skew-matrix lookup used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pok_pkg;

  // Default configuration of the block.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int ATAN_LEN         = 30;

  // Q30 constants of the sine and cosine unit.
  localparam logic signed [63:0] ONE30    = 64'sd1073741824;
  localparam logic signed [63:0] PI30     = 64'sd3373259426;
  localparam logic signed [63:0] HALFPI30 = 64'sd1686629713;
  localparam logic signed [63:0] GAIN30   = 64'sd652032874;

  // Result handed from the sine and cosine unit to the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [31:0] sin_q30;
    logic signed [31:0] cos_q30;
  } cordic_res_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:  val = 32'sd843314857;
      5'd1:  val = 32'sd497837829;
      5'd2:  val = 32'sd263043837;
      5'd3:  val = 32'sd133525159;
      5'd4:  val = 32'sd67021687;
      5'd5:  val = 32'sd33543516;
      5'd6:  val = 32'sd16775851;
      5'd7:  val = 32'sd8388437;
      5'd8:  val = 32'sd4194283;
      5'd9:  val = 32'sd2097149;
      5'd10: val = 32'sd1048576;
      5'd11: val = 32'sd524288;
      5'd12: val = 32'sd262144;
      5'd13: val = 32'sd131072;
      5'd14: val = 32'sd65536;
      5'd15: val = 32'sd32768;
      5'd16: val = 32'sd16384;
      5'd17: val = 32'sd8192;
      5'd18: val = 32'sd4096;
      5'd19: val = 32'sd2048;
      5'd20: val = 32'sd1024;
      5'd21: val = 32'sd512;
      5'd22: val = 32'sd256;
      5'd23: val = 32'sd128;
      5'd24: val = 32'sd64;
      5'd25: val = 32'sd32;
      5'd26: val = 32'sd16;
      5'd27: val = 32'sd8;
      5'd28: val = 32'sd4;
      5'd29: val = 32'sd2;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

  // Arithmetic right shift that rounds half up.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned sh);
    logic signed [63:0] rnd;
    rnd = 64'sd0;
    if (sh == 0) begin
      return v;
    end
    rnd = 64'sd1 <<< (sh - 1);
    return (v + rnd) >>> sh;
  endfunction

  // Clamp to the signed 32 bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Entry (i, j) of the skew matrix of the axis, Q14.
  function automatic logic signed [16:0] skew(input logic signed [15:0] w0,
                                              input logic signed [15:0] w1,
                                              input logic signed [15:0] w2,
                                              input logic [1:0] i,
                                              input logic [1:0] j);
    logic signed [16:0] r;
    case ({i, j})
      4'b0001: r = -17'(w2);
      4'b0010: r = 17'(w1);
      4'b0100: r = 17'(w2);
      4'b0110: r = -17'(w0);
      4'b1000: r = -17'(w1);
      4'b1001: r = 17'(w0);
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pok_cordic.sv
// ----------------------------------------------------------------------------
// pok_cordic: iterative sine and cosine unit
// Rotation-mode CORDIC in Q30, one micro-rotation per cycle, with quadrant
// folding for angles beyond a quarter turn and a final clamp to [-1, 1].
// ----------------------------------------------------------------------------
`default_nettype none

module pok_cordic #(
  parameter int CORDIC_STEPS = pok_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output pok_pkg::cordic_res_t    res
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);

  logic               busy_r, busy_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic               flip_r, flip_nxt;
  logic [IW-1:0]      it_r, it_nxt;
  logic signed [33:0] x_r, x_nxt;
  logic signed [33:0] y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic signed [31:0] sin_r, sin_nxt;
  logic signed [31:0] cos_r, cos_nxt;

  logic signed [35:0] ang;
  logic signed [33:0] dx, dy;
  logic signed [35:0] at;
  logic signed [33:0] xc, yc;

  // Angle in Q30 and the current micro-rotation terms.
  always_comb begin
    ang = 36'(angle) <<< 17;
    dx  = y_r >>> it_r;
    dy  = x_r >>> it_r;
    at  = 36'(pok_pkg::atan_q30(5'(it_r)));
  end

  // Clamp of the final vector to the unit range.
  always_comb begin
    if (x_r > 34'(pok_pkg::ONE30)) begin
      xc = 34'(pok_pkg::ONE30);
    end else if (x_r < -34'(pok_pkg::ONE30)) begin
      xc = -34'(pok_pkg::ONE30);
    end else begin
      xc = x_r;
    end
    if (y_r > 34'(pok_pkg::ONE30)) begin
      yc = 34'(pok_pkg::ONE30);
    end else if (y_r < -34'(pok_pkg::ONE30)) begin
      yc = -34'(pok_pkg::ONE30);
    end else begin
      yc = y_r;
    end
  end

  // Iteration control and datapath.
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    it_nxt   = it_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    sin_nxt  = sin_r;
    cos_nxt  = cos_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      x_nxt    = 34'(pok_pkg::GAIN30);
      y_nxt    = 34'sd0;
      if (ang > 36'(pok_pkg::HALFPI30)) begin
        z_nxt    = ang - 36'(pok_pkg::PI30);
        flip_nxt = 1'b1;
      end else if (ang < -36'(pok_pkg::HALFPI30)) begin
        z_nxt    = ang + 36'(pok_pkg::PI30);
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = ang;
        flip_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (!z_r[35]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      if (it_r == LAST_IT) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end else begin
        it_nxt = it_r + 1'b1;
      end
    end else if (fin_r) begin
      sin_nxt  = flip_r ? -32'(yc) : 32'(yc);
      cos_nxt  = flip_r ? -32'(xc) : 32'(xc);
      done_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    flip_r <= flip_nxt;
    it_r   <= it_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    sin_r  <= sin_nxt;
    cos_r  <= cos_nxt;
  end

  assign res.done    = done_r;
  assign res.sin_q30 = sin_r;
  assign res.cos_q30 = cos_r;

  // A result never appears while the rotation is still running.
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("cordic result raised while iterating");
  // Finishing always follows the last micro-rotation.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && it_r == LAST_IT |=> fin_r)
    else $error("cordic did not finish after last step");
  // The finish cycle is followed by the result pulse.
  assert property (@(posedge clk) disable iff (!rst_n) fin_r |=> done_r)
    else $error("cordic result missing after finish");

endmodule

`default_nettype wire

FILE: rtl/product_of_exponentials_kinematics.sv
// ----------------------------------------------------------------------------
// product_of_exponentials_kinematics: forward kinematics of a revolute chain
// Each input request carries one joint (unit axis, point on the axis, angle).
// The block builds the screw exponential of the joint and multiplies it into
// a running 3x4 transform in fixed point; on the last joint it emits the rows.
//
// Usage:
//   Input channel (in_*): a request is taken when in_valid is high and
//   in_stall is low. in_stall stays high until a joint and its rows are done.
//   Output channel (out_*): three requests, rows 0, 1 and 2, follow a joint
//   marked in_last_joint; out_last_row flags row 2. A joint without the mark
//   gives no output.
//   Processing: the accepted joint passes the sine and cosine unit, then 117
//   products go through the single shared 36x36 multiplier, one per cycle,
//   and then the drain state and the transform update state follow.
//   A new joint is taken only once the previous one is done; a closing
//   joint also holds off the next joint until its three rows are taken.
//   Reset sets the running transform to identity; after the third row is
//   taken it returns to identity. While out_stall is high the current row
//   holds and no new joint is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module product_of_exponentials_kinematics #(
  parameter int CORDIC_STEPS = pok_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = pok_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_axis_x,
  input  wire logic signed [15:0] in_axis_y,
  input  wire logic signed [15:0] in_axis_z,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic signed [15:0] in_joint_angle,
  input  wire logic               in_last_joint,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_row_index,
  output logic signed [31:0]      out_col_zero,
  output logic signed [31:0]      out_col_one,
  output logic signed [31:0]      out_col_two,
  output logic signed [31:0]      out_col_three,
  output logic                    out_last_row
);

  // Sequencer phases.
  localparam logic [3:0] P_IDLE   = 4'd0;
  localparam logic [3:0] P_CORDIC = 4'd1;
  localparam logic [3:0] P_W2     = 4'd2;
  localparam logic [3:0] P_V      = 4'd3;
  localparam logic [3:0] P_R      = 4'd4;
  localparam logic [3:0] P_G      = 4'd5;
  localparam logic [3:0] P_T      = 4'd6;
  localparam logic [3:0] P_CH     = 4'd7;
  localparam logic [3:0] P_DRAIN  = 4'd8;
  localparam logic [3:0] P_COPY   = 4'd9;
  localparam logic [3:0] P_OUT    = 4'd10;

  localparam logic signed [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [35:0] CH_UNIT = 36'(64'd1 << (FRAC_BITS - 2));
  localparam int unsigned SH_R  = 30 - FRAC_BITS;
  localparam int unsigned SH_T  = 36 - FRAC_BITS;
  localparam int unsigned SH_CH = FRAC_BITS - 2;

  // Descriptor of a product in flight to the accumulator.
  typedef struct packed {
    logic       vld;
    logic [3:0] ph;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic       first;
    logic       last;
  } tag_t;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] ci_r, ci_nxt;
  logic [1:0] cj_r, cj_nxt;
  logic [1:0] ck_r, ck_nxt;
  logic [1:0] row_r, row_nxt;
  tag_t       tag_r, tag_nxt;

  // Joint payload.
  logic signed [15:0] w_r [0:2];
  logic signed [31:0] q_r [0:2];
  logic signed [15:0] th_r;
  logic               last_r;

  // Intermediate values.
  logic signed [31:0] s_r;
  logic signed [32:0] omc_r;
  logic signed [26:0] tms_r;
  logic signed [32:0] w2_r [0:8];
  logic signed [34:0] v_r  [0:2];
  logic signed [26:0] g_r  [0:8];
  logic signed [31:0] e_r  [0:11];
  logic signed [31:0] nt_r [0:11];
  logic signed [31:0] rt_r [0:11];
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;

  pok_pkg::cordic_res_t cres;
  logic                 in_take;
  logic                 out_take;

  logic [1:0]         kmax, jmax, n1, n2;
  logic               issue;
  logic [3:0]         ph_after;
  logic [3:0]         ij9;
  logic [3:0]         ik9;
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] mul_p;
  logic signed [34:0] tms_d;
  logic signed [63:0] term, base, acc_cur, acc_sum;
  logic [3:0]         t9;

  assign in_stall  = (phase_r != P_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (phase_r == P_OUT);
  assign out_take  = out_valid && !out_stall;

  pok_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_take),
    .angle(in_joint_angle),
    .res  (cres)
  );

  // Loop bounds of the current phase.
  always_comb begin
    kmax     = 2'd2;
    jmax     = 2'd2;
    ph_after = P_DRAIN;
    unique case (phase_r)
      P_W2: begin
        ph_after = P_V;
      end
      P_V: begin
        kmax     = 2'd1;
        jmax     = 2'd0;
        ph_after = P_R;
      end
      P_R: begin
        kmax     = 2'd1;
        ph_after = P_G;
      end
      P_G: begin
        kmax     = 2'd1;
        ph_after = P_T;
      end
      P_T: begin
        // One dot product of a G row with v per row of the transform.
        jmax     = 2'd0;
        ph_after = P_CH;
      end
      P_CH: begin
        jmax     = 2'd3;
        kmax     = (cj_r == 2'd3) ? 2'd3 : 2'd2;
        ph_after = P_DRAIN;
      end
      default: begin
      end
    endcase
    issue = (phase_r == P_W2) || (phase_r == P_V) || (phase_r == P_R) ||
            (phase_r == P_G) || (phase_r == P_T) || (phase_r == P_CH);
    n1    = (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
    n2    = (n1 == 2'd2) ? 2'd0 : n1 + 2'd1;
    ij9   = 4'(ci_r) * 4'd3 + 4'(cj_r);
    ik9   = 4'(ci_r) * 4'd3 + 4'(ck_r);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 36'sd0;
    mul_b = 36'sd0;
    unique case (phase_r)
      P_W2: begin
        mul_a = 36'(pok_pkg::skew(w_r[0], w_r[1], w_r[2], ci_r, ck_r));
        mul_b = 36'(pok_pkg::skew(w_r[0], w_r[1], w_r[2], ck_r, cj_r));
      end
      P_V: begin
        mul_a = (ck_r == 2'd0) ? 36'(q_r[n1]) : 36'(q_r[n2]);
        mul_b = (ck_r == 2'd0) ? 36'(w_r[n2]) : 36'(w_r[n1]);
      end
      P_R: begin
        mul_a = (ck_r == 2'd0) ? 36'(s_r) : 36'(omc_r);
        mul_b = (ck_r == 2'd0) ? 36'(pok_pkg::skew(w_r[0], w_r[1], w_r[2], ci_r, cj_r))
                               : 36'(w2_r[ij9]);
      end
      P_G: begin
        mul_a = (ck_r == 2'd0) ? 36'(omc_r) : 36'(tms_r);
        mul_b = (ck_r == 2'd0) ? 36'(pok_pkg::skew(w_r[0], w_r[1], w_r[2], ci_r, cj_r))
                               : 36'(w2_r[ij9]);
      end
      P_T: begin
        mul_a = 36'(g_r[ik9]);
        mul_b = 36'(v_r[ck_r]);
      end
      P_CH: begin
        mul_a = 36'(rt_r[{ci_r, ck_r}]);
        mul_b = (ck_r == 2'd3) ? CH_UNIT : 36'(e_r[{ck_r, cj_r}]);
      end
      default: begin
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Sequencer: phase and loop counters.
  always_comb begin
    phase_nxt = phase_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    ck_nxt    = ck_r;
    row_nxt   = row_r;
    tag_nxt   = '0;
    if (issue) begin
      tag_nxt.vld   = 1'b1;
      tag_nxt.ph    = phase_r;
      tag_nxt.i     = ci_r;
      tag_nxt.j     = cj_r;
      tag_nxt.k     = ck_r;
      tag_nxt.first = (ck_r == 2'd0);
      tag_nxt.last  = (ck_r == kmax);
    end
    unique case (phase_r) inside
      P_IDLE: begin
        if (in_take) begin
          phase_nxt = P_CORDIC;
        end
      end
      P_CORDIC: begin
        if (cres.done) begin
          phase_nxt = P_W2;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
          ck_nxt    = 2'd0;
        end
      end
      P_W2, P_V, P_R, P_G, P_T, P_CH: begin
        if (ck_r != kmax) begin
          ck_nxt = ck_r + 2'd1;
        end else begin
          ck_nxt = 2'd0;
          if (cj_r != jmax) begin
            cj_nxt = cj_r + 2'd1;
          end else begin
            cj_nxt = 2'd0;
            if (ci_r != 2'd2) begin
              ci_nxt = ci_r + 2'd1;
            end else begin
              ci_nxt    = 2'd0;
              phase_nxt = ph_after;
            end
          end
        end
      end
      P_DRAIN: begin
        phase_nxt = P_COPY;
      end
      P_COPY: begin
        phase_nxt = last_r ? P_OUT : P_IDLE;
        row_nxt   = 2'd0;
      end
      P_OUT: begin
        if (out_take) begin
          row_nxt = row_r + 2'd1;
          if (row_r == 2'd2) begin
            phase_nxt = P_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  // Accumulator input: scaled product and starting value.
  always_comb begin
    term = prod_r;
    base = 64'sd0;
    case (tag_r.ph)
      P_V: begin
        term = (tag_r.k == 2'd0) ? prod_r : -prod_r;
      end
      P_R: begin
        term = (tag_r.k == 2'd0) ? pok_pkg::rshr(prod_r, 14) : pok_pkg::rshr(prod_r, 28);
        base = (tag_r.i == tag_r.j) ? pok_pkg::ONE30 : 64'sd0;
      end
      P_G: begin
        term = (tag_r.k == 2'd0) ? pok_pkg::rshr(prod_r, 24) : pok_pkg::rshr(prod_r, 30);
        base = (tag_r.i == tag_r.j) ? (64'(th_r) <<< 7) : 64'sd0;
      end
      P_CH: begin
        term = (tag_r.k == 2'd3) ? prod_r : (prod_r >>> 2);
      end
      default: begin
      end
    endcase
    acc_cur = tag_r.first ? base : acc_r;
    acc_sum = acc_cur + term;
    t9      = 4'(tag_r.i) * 4'd3 + 4'(tag_r.j);
    tms_d   = (35'(th_r) <<< 17) - 35'(cres.sin_q30);
  end

  // Control state and the running transform.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      ci_r    <= 2'd0;
      cj_r    <= 2'd0;
      ck_r    <= 2'd0;
      row_r   <= 2'd0;
      tag_r   <= '0;
      for (int n = 0; n < 12; n++) begin
        rt_r[n] <= ((n == 0) || (n == 5) || (n == 10)) ? ONE_Q : 32'sd0;
      end
    end else begin
      phase_r <= phase_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      ck_r    <= ck_nxt;
      row_r   <= row_nxt;
      tag_r   <= tag_nxt;
      if (phase_r == P_COPY) begin
        for (int n = 0; n < 12; n++) begin
          rt_r[n] <= nt_r[n];
        end
      end else if (out_take) begin
        if (row_r == 2'd2) begin
          for (int n = 0; n < 12; n++) begin
            rt_r[n] <= ((n == 0) || (n == 5) || (n == 10)) ? ONE_Q : 32'sd0;
          end
        end else begin
          // Move the next row up to the output slot.
          for (int n = 0; n < 8; n++) begin
            rt_r[n] <= rt_r[n + 4];
          end
          rt_r[8]  <= 32'sd0;
          rt_r[9]  <= 32'sd0;
          rt_r[10] <= ONE_Q;
          rt_r[11] <= 32'sd0;
        end
      end
    end
  end

  // Joint payload and sine/cosine derived terms.
  always_ff @(posedge clk) begin
    if (in_take) begin
      w_r[0] <= in_axis_x;
      w_r[1] <= in_axis_y;
      w_r[2] <= in_axis_z;
      q_r[0] <= in_point_x;
      q_r[1] <= in_point_y;
      q_r[2] <= in_point_z;
      th_r   <= in_joint_angle;
      last_r <= in_last_joint;
    end
    if (cres.done) begin
      s_r   <= cres.sin_q30;
      omc_r <= 33'(pok_pkg::ONE30) - 33'(cres.cos_q30);
      tms_r <= 27'((tms_d + 35'sd128) >>> 8);
    end
  end

  // Shared multiplier register, accumulator and result write-back.
  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    if (tag_r.vld) begin
      acc_r <= acc_sum;
      if (tag_r.last) begin
        case (tag_r.ph)
          P_W2: w2_r[t9] <= acc_sum[32:0];
          P_V:  v_r[tag_r.i] <= 35'(pok_pkg::rshr(acc_sum, 14));
          P_R:  e_r[{tag_r.i, tag_r.j}] <= pok_pkg::sat32(pok_pkg::rshr(acc_sum, SH_R));
          P_G:  g_r[t9] <= acc_sum[26:0];
          P_T:  e_r[{tag_r.i, 2'd3}] <= pok_pkg::sat32(pok_pkg::rshr(acc_sum, SH_T));
          P_CH: nt_r[{tag_r.i, tag_r.j}] <= pok_pkg::sat32(pok_pkg::rshr(acc_sum, SH_CH));
          default: begin
          end
        endcase
      end
    end
  end

  // Output row always sits in the first row slot.
  assign out_row_index = row_r;
  assign out_col_zero  = rt_r[0];
  assign out_col_one   = rt_r[1];
  assign out_col_two   = rt_r[2];
  assign out_col_three = rt_r[3];
  assign out_last_row  = (row_r == 2'd2);

  // Rows are only shown for a joint that closed the chain.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> last_r)
    else $error("rows shown for a joint that did not close the chain");
  // An accepted joint always starts the sine and cosine phase.
  assert property (@(posedge clk) disable iff (!rst_n) in_take |=> phase_r == P_CORDIC)
    else $error("accepted joint did not start processing");
  // A product in flight only exists while a joint is being processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.vld |-> (phase_r != P_IDLE) && (phase_r != P_OUT))
    else $error("product in flight outside of processing");
  // The row counter never passes the last row.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> row_r != 2'd3)
    else $error("row counter out of range");

endmodule

`default_nettype wire

FILE: tb/product_of_exponentials_kinematics_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the product-of-exponentials kinematics block
// Joints are sent through the in_* channel. A predictor in the testbench
// builds each screw exponential with its own CORDIC and folds it into its own
// copy of the running transform. The three rows of every finished chain are
// checked against the out_* channel. A short table of hand-picked joints runs
// first. Random chains follow, under four patterns of idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module product_of_exponentials_kinematics_tb;

  localparam int STEPS      = 16;
  localparam int FRAC       = 16;
  localparam int WATCHDOG   = 20000;
  localparam int PHASE_JNTS = 80;
  localparam int NUM_DIR    = 18;

  localparam logic signed [15:0] UNIT    = 16'sd16384;
  localparam logic signed [15:0] HALF_PI = 16'sd12868;
  localparam logic signed [15:0] PI_ANG  = 16'sd25736;
  localparam logic signed [31:0] PMAX    = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN    = 32'sh80000000;
  localparam logic signed [31:0] P_ONE   = 32'sd65536;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  // One joint request. The flag marks joints whose rows are typed in by hand.
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] ang;
    logic               last;
    logic               ident;
  } joint_t;

  // One output row.
  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               last_row;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_axis_x, in_axis_y, in_axis_z, in_joint_angle;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic in_last_joint;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col_zero, out_col_one, out_col_two, out_col_three;
  logic out_last_row;

  product_of_exponentials_kinematics DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_joint_angle(in_joint_angle), .in_last_joint(in_last_joint),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row_index(out_row_index),
    .out_col_zero(out_col_zero), .out_col_one(out_col_one),
    .out_col_two(out_col_two), .out_col_three(out_col_three),
    .out_last_row(out_last_row)
  );

  // Predictor state and the queue of rows still owed by the block.
  logic signed [31:0] chain_xform [12];
  row_t rows_due[$];
  longint atan_tbl [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  int errors;
  int joints_sent;
  int chains_done;
  int rows_seen;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  // Hand-picked joints: zero axes give an exact identity, then unit axes at
  // quarter and half turns, angle extremes, odd axes and saturating points.
  joint_t dir_tbl [NUM_DIR] = '{
    '{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b1, 1'b1},
    '{16'sd0, 16'sd0, 16'sd0, PMAX, PMIN, PMAX, 16'sh7fff, 1'b1, 1'b1},
    '{16'sd0, 16'sd0, 16'sd0, PMIN, PMAX, PMIN, 16'sh8000, 1'b1, 1'b1},
    '{16'sd0, 16'sd0, UNIT, P_ONE, 32'sd0, 32'sd0, HALF_PI, 1'b1, 1'b0},
    '{UNIT, 16'sd0, 16'sd0, 32'sd0, P_ONE, 32'sd0, -HALF_PI, 1'b1, 1'b0},
    '{16'sd0, UNIT, 16'sd0, 32'sd0, 32'sd0, P_ONE, PI_ANG, 1'b1, 1'b0},
    '{16'sd0, 16'sd0, -UNIT, P_ONE, P_ONE, 32'sd0, 16'sh7fff, 1'b1, 1'b0},
    '{-UNIT, 16'sd0, 16'sd0, 32'sd0, -P_ONE, P_ONE, -PI_ANG, 1'b1, 1'b0},
    '{16'sd0, -UNIT, 16'sd0, P_ONE, 32'sd0, -P_ONE, 16'sh8000, 1'b1, 1'b0},
    '{UNIT, UNIT, UNIT, P_ONE, 32'sd0, 32'sd0, 16'sd10000, 1'b1, 1'b0},
    '{16'sd0, 16'sd0, UNIT, PMAX, PMAX, 32'sd0, HALF_PI, 1'b1, 1'b0},
    '{-UNIT, -UNIT, -UNIT, PMIN, PMIN, PMAX, 16'sh8000, 1'b1, 1'b0},
    '{16'sd0, 16'sd0, UNIT, P_ONE, 32'sd0, 32'sd0, HALF_PI, 1'b0, 1'b0},
    '{UNIT, 16'sd0, 16'sd0, 32'sd0, P_ONE, 32'sd0, HALF_PI, 1'b0, 1'b0},
    '{16'sd0, UNIT, 16'sd0, 32'sd0, 32'sd0, P_ONE, -HALF_PI, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, UNIT, 32'sd0, 32'sd0, 32'sd0, PI_ANG, 1'b1, 1'b0},
    '{UNIT, 16'sd0, 16'sd0, PMIN, PMAX, PMAX, 16'sh7fff, 1'b0, 1'b0},
    '{16'sd0, UNIT, UNIT, PMAX, PMIN, PMIN, 16'sh8000, 1'b1, 1'b0}
  };

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return PMAX;
    end else if (v < -64'sd2147483648) begin
      return PMIN;
    end
    return v[31:0];
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    if (sh == 0) begin
      return v;
    end
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > ONE_Q30) begin
      return ONE_Q30;
    end else if (v < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return v;
  endfunction

  // Rotation-mode CORDIC in Q30, folded into the half turn around zero.
  task automatic sine_cosine(input longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    z = ang;
    flip = 0;
    if (z > HPI_Q30) begin
      z = z - PI_Q30;
      flip = 1;
    end else if (z < -HPI_Q30) begin
      z = z + PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tbl[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tbl[i];
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  task automatic reset_chain();
    foreach (chain_xform[i]) chain_xform[i] = '0;
    chain_xform[0]  = 32'sd1 <<< FRAC;
    chain_xform[5]  = 32'sd1 <<< FRAC;
    chain_xform[10] = 32'sd1 <<< FRAC;
  endtask

  // Build the joint exponential, fold it into the chain, queue rows on the
  // last joint.
  task automatic fold_joint(input joint_t jt);
    longint w [3];
    longint q [3];
    longint v [3];
    longint skw [3][3];
    longint skw2 [3][3];
    logic signed [31:0] ex [12];
    logic signed [31:0] nx [12];
    longint th, sn, cs, omc, tms, r, g, t, acc;
    row_t rw;
    w[0] = jt.ax; w[1] = jt.ay; w[2] = jt.az;
    q[0] = jt.px; q[1] = jt.py; q[2] = jt.pz;
    th = jt.ang;
    sine_cosine(th * 131072, sn, cs);
    omc = ONE_Q30 - cs;
    tms = round_shift(th * 131072 - sn, 8);
    skw[0][0] = 0;     skw[0][1] = -w[2]; skw[0][2] = w[1];
    skw[1][0] = w[2];  skw[1][1] = 0;     skw[1][2] = -w[0];
    skw[2][0] = -w[1]; skw[2][1] = w[0];  skw[2][2] = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        skw2[i][j] = 0;
        for (int k = 0; k < 3; k++) skw2[i][j] += skw[i][k] * skw[k][j];
      end
    end
    v[0] = round_shift(q[1] * w[2] - q[2] * w[1], 14);
    v[1] = round_shift(q[2] * w[0] - q[0] * w[2], 14);
    v[2] = round_shift(q[0] * w[1] - q[1] * w[0], 14);
    for (int i = 0; i < 3; i++) begin
      t = 0;
      for (int j = 0; j < 3; j++) begin
        r = (i == j) ? ONE_Q30 : 0;
        g = (i == j) ? th * 128 : 0;
        r += round_shift(sn * skw[i][j], 14) + round_shift(omc * skw2[i][j], 28);
        g += round_shift(omc * skw[i][j], 24) + round_shift(tms * skw2[i][j], 30);
        ex[i * 4 + j] = clip32(round_shift(r, 30 - FRAC));
        t += g * v[j];
      end
      ex[i * 4 + 3] = clip32(round_shift(t, 36 - FRAC));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          acc += (longint'(chain_xform[i * 4 + k]) * longint'(ex[k * 4 + j])) >>> 2;
        end
        if (j == 3) begin
          acc += longint'(chain_xform[i * 4 + 3]) * (64'sd1 <<< (FRAC - 2));
        end
        nx[i * 4 + j] = clip32(round_shift(acc, FRAC - 2));
      end
    end
    chain_xform = nx;
    if (jt.last) begin
      for (int i = 0; i < 3; i++) begin
        rw.row = 2'(i);
        rw.last_row = (i == 2);
        if (jt.ident) begin
          // A zero axis leaves an identity chain untouched.
          rw.c0 = (i == 0) ? P_ONE : 32'sd0;
          rw.c1 = (i == 1) ? P_ONE : 32'sd0;
          rw.c2 = (i == 2) ? P_ONE : 32'sd0;
          rw.c3 = 32'sd0;
        end else begin
          rw.c0 = chain_xform[i * 4];
          rw.c1 = chain_xform[i * 4 + 1];
          rw.c2 = chain_xform[i * 4 + 2];
          rw.c3 = chain_xform[i * 4 + 3];
        end
        rows_due.push_back(rw);
      end
      chains_done++;
      reset_chain();
    end
  endtask

  // Drive one joint request from a falling edge and hold it until taken.
  task automatic send_joint(input joint_t jt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_axis_x      = jt.ax;
    in_axis_y      = jt.ay;
    in_axis_z      = jt.az;
    in_point_x     = jt.px;
    in_point_y     = jt.py;
    in_point_z     = jt.pz;
    in_joint_angle = jt.ang;
    in_last_joint  = jt.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_joint(jt);
    joints_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis_comp();
    case ($urandom_range(3))
      0: return UNIT;
      1: return -UNIT;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_point();
    if ($urandom_range(4) == 0) begin
      return $urandom;
    end
    return 32'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
  endfunction

  // Random joint: mostly a single principal axis, sometimes an arbitrary one.
  function automatic joint_t rand_joint(input logic last);
    joint_t jt;
    int pick;
    pick = $urandom_range(5);
    jt.ax = (pick == 0) ? UNIT : (pick == 1) ? -UNIT : 16'sd0;
    jt.ay = (pick == 2) ? UNIT : (pick == 3) ? -UNIT : 16'sd0;
    jt.az = (pick == 4) ? ((($urandom_range(1)) != 0) ? UNIT : -UNIT) : 16'sd0;
    if (pick == 5) begin
      jt.ax = rand_axis_comp();
      jt.ay = rand_axis_comp();
      jt.az = rand_axis_comp();
    end
    jt.px    = rand_point();
    jt.py    = rand_point();
    jt.pz    = rand_point();
    jt.ang   = 16'($urandom);
    jt.last  = last;
    jt.ident = 1'b0;
    return jt;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result stall pattern, redrawn at every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every taken row with the oldest owed one.
  always @(posedge clk) begin
    row_t exp_row;
    if (rst_n && out_valid && !out_stall) begin
      rows_seen++;
      if (rows_due.size() == 0) begin
        $error("row with nothing owed: row_index %0d", out_row_index);
        errors++;
      end else begin
        exp_row = rows_due.pop_front();
        if (out_row_index !== exp_row.row) begin
          $error("row_index: expected %0d, actual %0d", exp_row.row, out_row_index);
          errors++;
        end
        if (out_col_zero !== exp_row.c0) begin
          $error("col_zero: expected %0d, actual %0d", exp_row.c0, out_col_zero);
          errors++;
        end
        if (out_col_one !== exp_row.c1) begin
          $error("col_one: expected %0d, actual %0d", exp_row.c1, out_col_one);
          errors++;
        end
        if (out_col_two !== exp_row.c2) begin
          $error("col_two: expected %0d, actual %0d", exp_row.c2, out_col_two);
          errors++;
        end
        if (out_col_three !== exp_row.c3) begin
          $error("col_three: expected %0d, actual %0d", exp_row.c3, out_col_three);
          errors++;
        end
        if (out_last_row !== exp_row.last_row) begin
          $error("last_row: expected %0d, actual %0d", exp_row.last_row, out_last_row);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: no request moved for %0d cycles", WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int left;
    int chain_len;
    errors         = 0;
    joints_sent    = 0;
    chains_done    = 0;
    rows_seen      = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_axis_x      = '0;
    in_axis_y      = '0;
    in_axis_z      = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_point_z     = '0;
    in_joint_angle = '0;
    in_last_joint  = 1'b0;
    out_stall      = 1'b0;
    reset_chain();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    for (int i = 0; i < NUM_DIR; i++) send_joint(dir_tbl[i]);

    // Random chains under each idle pattern; every phase ends on a last joint.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 24) : 0;
      left = PHASE_JNTS;
      while (left > 0) begin
        chain_len = $urandom_range(1, 6);
        if (chain_len > left) chain_len = left;
        for (int k = 0; k < chain_len; k++) begin
          send_joint(rand_joint(k == chain_len - 1));
        end
        left -= chain_len;
      end
      in_valid = 1'b0;
      while (rows_due.size() != 0) @(negedge clk);
    end

    recv_stall_pct = 0;
    repeat (300) @(negedge clk);
    $display("Covered %0d joints in %0d chains; %0d rows checked.",
             joints_sent, chains_done, rows_seen);
    $display("Idle patterns: none, sender 64%%, receiver 64%%, both 24%%.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
